// ===== src/bfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the BFS walk block.
package bfs_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = 4;   // node number field
  localparam int CNT_W     = 5;   // edge count / node count field
  localparam int ROW_W     = 16;  // adjacency row field
  localparam int PTR_W     = $clog2(MAX_NODES + 1);

  localparam logic [CNT_W-1:0] NODE_CAP = CNT_W'((MAX_NODES < ROW_W) ? MAX_NODES : ROW_W);
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(6);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  localparam logic KIND_VISIT = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_row;
    logic run_init;
    logic visit;
    logic enqueue;
    logic count_emit;
  } bfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_ok;
    logic queue_nonempty;
    logic has_cand;
    logic count_last;
  } bfs_stat_t;

  // node count in use: saturate to 1..NODE_CAP
  function automatic logic [CNT_W-1:0] nodes_in_use(input logic [CNT_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    n = cfg;
    if (n == '0) n = CNT_W'(1);
    if (n > NODE_CAP) n = NODE_CAP;
    return n;
  endfunction

  // lowest set bit of a nonzero row
  function automatic logic [NODE_W-1:0] lowest_bit(input logic [MAX_NODES-1:0] v);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (v[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== src/bfs_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine for the BFS walk: load, visit, expand, count.
module bfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               mode,
  input  bfs_pkg::bfs_stat_t stat,
  output bfs_pkg::bfs_cmd_t  cmd,
  output logic               busy
);
  import bfs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VISIT,
    ST_EXPAND,
    ST_COUNT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_RUN) begin
            cmd.run_init = 1'b1;
            state_next   = stat.start_ok ? ST_VISIT : ST_COUNT;
          end else begin
            cmd.load_row = 1'b1;
          end
        end
      end
      ST_VISIT: begin
        cmd.visit  = 1'b1;
        state_next = ST_EXPAND;
      end
      ST_EXPAND: begin
        if (stat.has_cand) begin
          cmd.enqueue = 1'b1;
        end else if (stat.queue_nonempty) begin
          state_next = ST_VISIT;
        end else begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.count_emit = 1'b1;
        if (stat.count_last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

// ===== src/bfs_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: adjacency rows, visit queue, seen marks, incoming counts, result register.
module bfs_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  bfs_pkg::bfs_cmd_t            cmd,
  output bfs_pkg::bfs_stat_t           stat,
  input  logic [bfs_pkg::CNT_W-1:0]    node_count,
  input  logic [bfs_pkg::NODE_W-1:0]   row_index,
  input  logic [bfs_pkg::ROW_W-1:0]    row_bits,
  input  logic [bfs_pkg::NODE_W-1:0]   start_node,
  output logic                         result_valid,
  output logic                         kind,
  output logic [bfs_pkg::NODE_W-1:0]   node,
  output logic [bfs_pkg::CNT_W-1:0]    edge_count,
  output logic                         last
);
  import bfs_pkg::*;

  logic [ROW_W-1:0]     adj [MAX_NODES];
  logic [NODE_W-1:0]    queue [MAX_NODES];
  logic [CNT_W-1:0]     totals [MAX_NODES];
  logic [MAX_NODES-1:0] seen;
  logic [MAX_NODES-1:0] cur_row;
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic [NODE_W-1:0]    cnt_idx;
  logic [CNT_W-1:0]     n_use;

  logic [CNT_W-1:0]     n_cfg;
  logic [MAX_NODES-1:0] node_mask;
  logic [NODE_W-1:0]    head_node;
  logic [MAX_NODES-1:0] head_row;
  logic [MAX_NODES-1:0] cand;
  logic [NODE_W-1:0]    cand_idx;

  assign n_cfg     = nodes_in_use(node_count);
  assign head_node = queue[head[NODE_W-1:0]];
  assign cand      = cur_row & ~seen;
  assign cand_idx  = lowest_bit(cand);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      node_mask[i] = (CNT_W'(i) < n_use);
    end
  end

  assign head_row = adj[head_node][MAX_NODES-1:0] & node_mask;

  assign stat.start_ok       = ({1'b0, start_node} < n_cfg);
  assign stat.queue_nonempty = (head < tail);
  assign stat.has_cand       = (cand != '0);
  assign stat.count_last     = ((CNT_W'(cnt_idx) + CNT_W'(1)) == n_use);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      seen         <= '0;
      head         <= '0;
      tail         <= '0;
      cnt_idx      <= '0;
      n_use        <= CNT_W'(1);
    end else begin
      result_valid <= cmd.visit | cmd.count_emit;
      if (cmd.run_init) begin
        n_use   <= n_cfg;
        head    <= '0;
        cnt_idx <= '0;
        if (stat.start_ok) begin
          seen <= {{(MAX_NODES-1){1'b0}}, 1'b1} << start_node;
          tail <= PTR_W'(1);
        end else begin
          seen <= '0;
          tail <= '0;
        end
      end
      if (cmd.visit) head <= head + PTR_W'(1);
      if (cmd.enqueue) begin
        seen[cand_idx] <= 1'b1;
        tail           <= tail + PTR_W'(1);
      end
      if (cmd.count_emit) cnt_idx <= cnt_idx + NODE_W'(1);
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (cmd.load_row) adj[row_index] <= row_bits;
    if (cmd.run_init) begin
      queue[0] <= start_node;
      for (int i = 0; i < MAX_NODES; i++) totals[i] <= '0;
    end
    if (cmd.visit) begin
      cur_row <= head_row;
      for (int i = 0; i < MAX_NODES; i++) begin
        totals[i] <= totals[i] + CNT_W'(head_row[i]);
      end
      kind       <= KIND_VISIT;
      node       <= head_node;
      edge_count <= '0;
      last       <= 1'b0;
    end
    if (cmd.enqueue) queue[tail[NODE_W-1:0]] <= cand_idx;
    if (cmd.count_emit) begin
      kind       <= KIND_COUNT;
      node       <= cnt_idx;
      edge_count <= totals[cnt_idx];
      last       <= stat.count_last;
    end
  end

endmodule

// ===== src/bfs_walk_with_indegree_count.sv =====
`timescale 1ns / 1ps
// Top level of the BFS walk with incoming edge count: config register, controller, datapath.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  command   | start / busy           | mode, row_index, row_bits, start_node
//  result    | result_valid (strobe)  | kind, node, edge_count, last
//  config    | cfg_we                 | cfg_data (node count)
//
// A command transfers on a clock edge with start high and busy low.
// A row load leaves busy low, so loads can stream back to back.
// A run alternates a visit step and an expand step for each queued node, where the
// expand step enqueues every newly found neighbor before moving on, then reports the
// incoming count of each node in use; a bad start node goes straight to the reports.
// Each result is shown for one cycle and must be taken then: there is no stall.
// Synchronous active-high reset; node count resets to 6, rows are unknown until loaded.
module bfs_walk_with_indegree_count (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [bfs_pkg::NODE_W-1:0]   row_index,
  input  logic [bfs_pkg::ROW_W-1:0]    row_bits,
  input  logic [bfs_pkg::NODE_W-1:0]   start_node,
  // config write
  input  logic                         cfg_we,
  input  logic [bfs_pkg::CNT_W-1:0]    cfg_data,
  // result channel
  output logic                         result_valid,
  output logic                         kind,
  output logic [bfs_pkg::NODE_W-1:0]   node,
  output logic [bfs_pkg::CNT_W-1:0]    edge_count,
  output logic                         last
);
  import bfs_pkg::*;

  logic [CNT_W-1:0] node_count;
  bfs_cmd_t         cmd;
  bfs_stat_t        stat;

  // node count register, raw value; saturation happens in the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  bfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bfs_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .node_count   (node_count),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .start_node   (start_node),
    .result_valid (result_valid),
    .kind         (kind),
    .node         (node),
    .edge_count   (edge_count),
    .last         (last)
  );

endmodule
